### rtl/core/circle_pair_collision_response_assert.svh
// Assertion macros used by the collision response top level.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/cpc_pkg.sv
// Package with the widths, types and helpers of the collision response block.
`default_nettype none
package cpc_pkg;
    localparam int unsigned POS_W = 17;
    localparam int unsigned VEL_W = 16;
    localparam int unsigned RAD_W = 6;
    localparam int unsigned ARENA_W = 10;
    localparam logic [ARENA_W-1:0] ARENA_RESET = 10'd640;
    localparam logic [1:0] ADDR_ARENA = 2'd0;
    // Numerator width: |v|*63 + 2*63*|v| < 2^23, so 25 bits signed is ample.
    localparam int unsigned NUM_W = 25;
    localparam int unsigned QUO_W = NUM_W;
    localparam int unsigned DEN_W = RAD_W + 1;

    // Saturate a wide signed value to the velocity range.
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [NUM_W:0] v);
        logic signed [NUM_W:0] hi;
        logic signed [NUM_W:0] lo;
        hi = (NUM_W+1)'(32767);
        lo = -(NUM_W+1)'(32768);
        if (v > hi) sat_vel = 16'sh7fff;
        else if (v < lo) sat_vel = 16'sh8000;
        else sat_vel = v[VEL_W-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/cpc_divider.sv
// Pipelined restoring divider: signed numerator by unsigned mass sum, truncating.
`default_nettype none
module cpc_divider import cpc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     adv,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]         den,
    output logic signed [VEL_W-1:0]       quo
);
    // Four bits per stage over six stages covers the 24 magnitude bits.
    localparam int unsigned MAG_W = NUM_W - 1;
    localparam int unsigned BPS = 4;
    localparam int unsigned NST = MAG_W / BPS;

    logic [MAG_W-1:0] rem_reg [NST+1];
    logic [MAG_W-1:0] q_reg   [NST+1];
    logic [DEN_W-1:0] den_reg [NST+1];
    logic             neg_reg [NST+1];
    logic [MAG_W-1:0] rem_next [NST];
    logic [MAG_W-1:0] q_next   [NST];

    // Stage 0 takes magnitude and sign.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NUM_W-1];
        end
    end

    // Long division: q builds the remainder; rem takes the quotient bits.
    for (genvar s = 0; s < NST; s++) begin : g_st
        always_comb begin
            logic [MAG_W:0] part;
            logic [MAG_W-1:0] r;
            logic [MAG_W-1:0] q;
            r = rem_reg[s];
            q = q_reg[s];
            part = '0;
            for (int b = 0; b < BPS; b++) begin
                part = (MAG_W+1)'(q) << 1 | (MAG_W+1)'(r[MAG_W-1]);
                r = r << 1;
                if (part[MAG_W:0] >= (MAG_W+1)'(den_reg[s])) begin
                    q = part[MAG_W-1:0] - MAG_W'(den_reg[s]);
                    r[0] = 1'b1;
                end else begin
                    q = part[MAG_W-1:0];
                end
            end
            rem_next[s] = r;
            q_next[s] = q;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s+1] <= rem_next[s];
                q_reg[s+1]   <= q_next[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    // After all steps rem holds the quotient magnitude; q_reg holds the remainder.
    always_comb begin
        logic signed [NUM_W:0] v;
        v = {2'b00, rem_reg[NST]};
        if (neg_reg[NST]) v = -v;
        quo = sat_vel(v);
    end
endmodule
`default_nettype wire

### rtl/core/circle_pair_collision_response.sv
// Top level of the circle pair collision response pipeline.
// Usage: one circle pair enters as a word on the s_ stream; one result word
// leaves on the m_ stream per pair, in order. The arena side is to be set
// through the APB port (register 0 at address 0, reset 640) only while the
// block is idle; the block itself does not enforce this. Throughput is one
// word per cycle while the output is not stalled. The pipeline length is set
// by the delta, square and numerator stages, the divider (an input register
// and six stages of four quotient bits each) and the wall and output register.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// arena size. When the receiver holds m_tready low with a valid word on
// m_tvalid the whole pipeline halts with its contents kept; s_tready then falls
// only once the output register is full, so no word is lost or repeated.
`default_nettype none
module circle_pair_collision_response import cpc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_x, a_y, a_radius, a_vx, a_vy, b_x, b_y, b_radius, b_vx, b_vy
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // collided, new_a_vx, new_a_vy, new_b_vx, new_b_vy, zero pad
    output logic [71:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
`include "circle_pair_collision_response_assert.svh"
    localparam int unsigned DLAT = 7;
    localparam int unsigned NV = 11;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0] r;
    } circ_t;

    logic [ARENA_W-1:0] arena_reg;
    logic [NV-1:0] vld_reg;
    logic adv;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) arena_reg <= ARENA_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_ARENA)
            arena_reg <= pwdata[ARENA_W-1:0];
    end
    assign prdata = (paddr == ADDR_ARENA) ? {22'd0, arena_reg} : 32'd0;

    // Whole pipeline advances unless the output word is held.
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NV-1];
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[NV-2:0], s_tvalid};
    end

    // Unpack input word.
    logic signed [POS_W-1:0] ax, ay, bx, by;
    logic [RAD_W-1:0] ar, br;
    logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
    assign ax  = s_tdata[16:0];
    assign ay  = s_tdata[33:17];
    assign ar  = s_tdata[39:34];
    assign avx = s_tdata[55:40];
    assign avy = s_tdata[71:56];
    assign bx  = s_tdata[88:72];
    assign by  = s_tdata[105:89];
    assign br  = s_tdata[111:106];
    assign bvx = s_tdata[127:112];
    assign bvy = s_tdata[143:128];

    // Stage 1: deltas and radius sum, register inputs.
    logic signed [POS_W:0] dx_reg, dy_reg;
    logic [RAD_W:0] rs_reg;
    circ_t ca_reg [3], cb_reg [3];
    logic signed [VEL_W-1:0] v1_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= (POS_W+1)'(bx) - (POS_W+1)'(ax);
            dy_reg <= (POS_W+1)'(by) - (POS_W+1)'(ay);
            rs_reg <= (RAD_W+1)'(ar) + (RAD_W+1)'(br);
            ca_reg[0] <= '{ax, ay, ar};
            cb_reg[0] <= '{bx, by, br};
            v1_reg <= '{avx, avy, bvx, bvy};
        end
    end

    // Stage 2: squares.
    logic [2*POS_W+1:0] dx2_reg, dy2_reg;
    logic [2*(RAD_W+7)-1:0] rs2_reg;
    logic signed [VEL_W-1:0] v2_reg [4];
    logic [RAD_W:0] rs2s_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx2_reg <= (2*POS_W+2)'(dx_reg * dx_reg);
            dy2_reg <= (2*POS_W+2)'(dy_reg * dy_reg);
            rs2_reg <= (2*(RAD_W+7))'({rs_reg, 6'd0} * {rs_reg, 6'd0});
            ca_reg[1] <= ca_reg[0];
            cb_reg[1] <= cb_reg[0];
            v2_reg <= v1_reg;
            rs2s_reg <= rs_reg;
        end
    end

    // Stage 3: overlap compare and exchange numerators.
    logic hit_reg;
    logic signed [NUM_W-1:0] num_reg [4];
    logic [DEN_W-1:0] den_reg;
    logic signed [VEL_W-1:0] v3_reg [4];
    always_ff @(posedge aclk) begin
        logic signed [RAD_W+1:0] dab, dba;
        logic signed [RAD_W+2:0] ta, tb;
        dab = (RAD_W+2)'(ca_reg[1].r) - (RAD_W+2)'(cb_reg[1].r);
        dba = -dab;
        ta = {2'b00, ca_reg[1].r, 1'b0};
        tb = {2'b00, cb_reg[1].r, 1'b0};
        if (adv) begin
            hit_reg <= ((2*POS_W+3)'(dx2_reg) + (2*POS_W+3)'(dy2_reg))
                       < (2*POS_W+3)'(rs2_reg);
            num_reg[0] <= NUM_W'(v2_reg[0] * dab) + NUM_W'(v2_reg[2] * tb);
            num_reg[1] <= NUM_W'(v2_reg[1] * dab) + NUM_W'(v2_reg[3] * tb);
            num_reg[2] <= NUM_W'(v2_reg[2] * dba) + NUM_W'(v2_reg[0] * ta);
            num_reg[3] <= NUM_W'(v2_reg[3] * dba) + NUM_W'(v2_reg[1] * ta);
            den_reg <= rs2s_reg;
            ca_reg[2] <= ca_reg[1];
            cb_reg[2] <= cb_reg[1];
            v3_reg <= v2_reg;
        end
    end

    // Divider bank; den is never zero on overlap.
    logic signed [VEL_W-1:0] q [4];
    for (genvar i = 0; i < 4; i++) begin : g_div
        cpc_divider u_div (.aclk(aclk), .adv(adv), .num(num_reg[i]),
                           .den(den_reg), .quo(q[i]));
    end

    // Side data delayed through the divider latency.
    logic hit_d_reg [DLAT];
    circ_t ca_d_reg [DLAT], cb_d_reg [DLAT];
    logic signed [VEL_W-1:0] v_d_reg [DLAT][4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_d_reg[0] <= hit_reg;
            ca_d_reg[0] <= ca_reg[2];
            cb_d_reg[0] <= cb_reg[2];
            v_d_reg[0] <= v3_reg;
            for (int k = 1; k < DLAT; k++) begin
                hit_d_reg[k] <= hit_d_reg[k-1];
                ca_d_reg[k] <= ca_d_reg[k-1];
                cb_d_reg[k] <= cb_d_reg[k-1];
                v_d_reg[k] <= v_d_reg[k-1];
            end
        end
    end

    // Wall test for one axis: low wall first, then high wall with that velocity.
    function automatic logic signed [VEL_W-1:0] bounce(
        input logic signed [POS_W-1:0] p, input logic [RAD_W-1:0] r,
        input logic signed [VEL_W-1:0] v, input logic [ARENA_W-1:0] a);
        logic signed [21:0] p4, r256, e;
        logic signed [VEL_W-1:0] w;
        p4 = {{3{p[POS_W-1]}}, p, 2'b00};
        r256 = {8'd0, r, 8'd0};
        e = {4'd0, a, 8'd0};
        w = v;
        if (p4 - r256 + 22'(w) < 0) w = (w == 16'sh8000) ? 16'sh7fff : -w;
        if (p4 + r256 + 22'(w) > e) w = (w == 16'sh8000) ? 16'sh7fff : -w;
        bounce = w;
    endfunction

    // Stage wall: bounce and select into the output register.
    logic hit_o_reg;
    logic signed [VEL_W-1:0] vo_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_o_reg <= hit_d_reg[DLAT-1];
            if (hit_d_reg[DLAT-1]) begin
                vo_reg[0] <= bounce(ca_d_reg[DLAT-1].x, ca_d_reg[DLAT-1].r, q[0], arena_reg);
                vo_reg[1] <= bounce(ca_d_reg[DLAT-1].y, ca_d_reg[DLAT-1].r, q[1], arena_reg);
                vo_reg[2] <= bounce(cb_d_reg[DLAT-1].x, cb_d_reg[DLAT-1].r, q[2], arena_reg);
                vo_reg[3] <= bounce(cb_d_reg[DLAT-1].y, cb_d_reg[DLAT-1].r, q[3], arena_reg);
            end else begin
                vo_reg <= v_d_reg[DLAT-1];
            end
        end
    end

    assign m_tdata = {7'd0, vo_reg[3], vo_reg[2], vo_reg[1], vo_reg[0], hit_o_reg};

    // Checks on pipeline control.
    `CPC_ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `CPC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
    `CPC_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
endmodule
`default_nettype wire
